@@ src/cps_pkg.sv @@
// Shared types and constants for the contactor precharge sequencer.
`timescale 1ns / 1ps

package cps_pkg;

	// Configuration register width and index width.
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAIT_START = 2'd0,
		REG_PRECHARGE  = 2'd1,
		REG_SETTLE     = 2'd2
	} cps_reg_idx_t;

	// Reset values of the configuration registers, in ticks.
	localparam logic [CFG_W-1:0] WAIT_START_RST = 16'd200;
	localparam logic [CFG_W-1:0] PRECHARGE_RST  = 16'd5570;
	localparam logic [CFG_W-1:0] SETTLE_RST     = 16'd1000;

	// Phase codes as shown on the result channel.
	localparam logic [2:0] PC_START     = 3'd0;
	localparam logic [2:0] PC_WAIT      = 3'd1;
	localparam logic [2:0] PC_PRECHARGE = 3'd2;
	localparam logic [2:0] PC_MAIN_ON   = 3'd3;
	localparam logic [2:0] PC_RUN       = 3'd4;
	localparam logic [2:0] PC_SHUTDOWN  = 3'd5;

	// One-hot sequencer state.
	typedef enum logic [5:0] {
		PH_START     = 6'b000001,
		PH_WAIT      = 6'b000010,
		PH_PRECHARGE = 6'b000100,
		PH_MAIN_ON   = 6'b001000,
		PH_RUN       = 6'b010000,
		PH_SHUTDOWN  = 6'b100000
	} cps_phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] wait_start;
		logic [CFG_W-1:0] precharge;
		logic [CFG_W-1:0] settle;
	} cps_cfg_t;

	typedef struct packed {
		logic loop_tripped;
		logic start_request;
		logic stop_request;
	} cps_cmd_t;

	typedef struct packed {
		logic       main_closed;
		logic       precharge_closed;
		logic       discharge_closed;
		logic       levitation_power;
		logic [2:0] phase_code;
	} cps_drive_t;

endpackage

@@ src/cps_cfg_regs.sv @@
// Configuration register file for the contactor precharge sequencer.
`timescale 1ns / 1ps

module cps_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cps_pkg::CFG_W-1:0]      cfg_data,
	output cps_pkg::cps_cfg_t              cfg
);
	import cps_pkg::*;

	cps_cfg_t cfg_q;

	// Writes are always taken; an index past the last register is dropped.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_start <= WAIT_START_RST;
			cfg_q.precharge  <= PRECHARGE_RST;
			cfg_q.settle     <= SETTLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cps_reg_idx_t'(cfg_index))
				REG_WAIT_START: cfg_q.wait_start <= cfg_data;
				REG_PRECHARGE:  cfg_q.precharge  <= cfg_data;
				REG_SETTLE:     cfg_q.settle     <= cfg_data;
				default:        ;
			endcase
		end
	end

endmodule

@@ src/cps_step.sv @@
// Next-state, phase timer and contactor drive logic for one tick.
`timescale 1ns / 1ps

module cps_step #(
	parameter int unsigned TICK_BITS = 16
) (
	input  cps_pkg::cps_phase_t    phase,
	input  logic [TICK_BITS-1:0]   ticks,
	input  cps_pkg::cps_cmd_t      cmd,
	input  cps_pkg::cps_cfg_t      cfg,
	output cps_pkg::cps_phase_t    phase_nxt,
	output logic [TICK_BITS-1:0]   ticks_nxt,
	output cps_pkg::cps_drive_t    drive
);
	import cps_pkg::*;

	localparam int unsigned CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

	logic [TICK_BITS-1:0] ticks_inc;
	logic [CMP_W-1:0]     ticks_ext;
	logic                 wait_done;
	logic                 precharge_done;
	logic                 settle_done;
	logic                 enter;

	// The count saturates at all ones.
	assign ticks_inc = (&ticks) ? ticks : ticks + TICK_BITS'(1);
	assign ticks_ext = CMP_W'(ticks_inc);

	assign wait_done      = ticks_ext >= CMP_W'(cfg.wait_start);
	assign precharge_done = ticks_ext >= CMP_W'(cfg.precharge);
	assign settle_done    = ticks_ext >= CMP_W'(cfg.settle);

	always_comb begin
		phase_nxt = phase;
		enter     = 1'b0;
		if (cmd.loop_tripped) begin
			// A trip inside shutdown does not restart the phase timer.
			if (phase != PH_SHUTDOWN) begin
				phase_nxt = PH_SHUTDOWN;
				enter     = 1'b1;
			end
		end else begin
			unique case (phase)
				PH_START: if (cmd.start_request) begin
					phase_nxt = PH_WAIT;
					enter     = 1'b1;
				end
				PH_WAIT: if (wait_done) begin
					phase_nxt = PH_PRECHARGE;
					enter     = 1'b1;
				end
				PH_PRECHARGE: if (precharge_done) begin
					phase_nxt = PH_MAIN_ON;
					enter     = 1'b1;
				end
				PH_MAIN_ON: if (settle_done) begin
					phase_nxt = PH_RUN;
					enter     = 1'b1;
				end
				PH_RUN: if (cmd.stop_request) begin
					phase_nxt = PH_SHUTDOWN;
					enter     = 1'b1;
				end
				PH_SHUTDOWN: ;
				default: begin
					phase_nxt = PH_SHUTDOWN;
					enter     = 1'b1;
				end
			endcase
		end
		ticks_nxt = enter ? '0 : ticks_inc;
	end

	always_comb begin
		unique case (phase_nxt)
			PH_START:     drive = '{1'b0, 1'b0, 1'b1, 1'b0, PC_START};
			PH_WAIT:      drive = '{1'b0, 1'b0, 1'b1, 1'b0, PC_WAIT};
			PH_PRECHARGE: drive = '{1'b0, 1'b1, 1'b0, 1'b0, PC_PRECHARGE};
			PH_MAIN_ON:   drive = '{1'b1, 1'b1, 1'b0, 1'b0, PC_MAIN_ON};
			PH_RUN:       drive = '{1'b1, 1'b0, 1'b0, 1'b1, PC_RUN};
			PH_SHUTDOWN:  drive = '{1'b0, 1'b0, 1'b1, 1'b0, PC_SHUTDOWN};
			default:      drive = '{1'b0, 1'b0, 1'b1, 1'b0, PC_SHUTDOWN};
		endcase
	end

endmodule

@@ src/contactor_precharge_sequencer_core.sv @@
// Top level of the DC bus precharge contactor sequencer.
`timescale 1ns / 1ps

// Each input transfer is one millisecond tick carrying the shutdown-loop trip
// level and the start and stop requests; each tick yields exactly one result
// transfer with the main, precharge and discharge contactor drives, the
// levitation power enable and the phase code (0 start, 1 wait, 2 precharge,
// 3 main on, 4 run, 5 shutdown) after that tick's update. The block takes
// one tick per clock cycle when the result side does not stall: a tick is
// captured in an input register, the phase and phase timer are updated in
// one pass of compare logic, and the result is held in an output register.
// The input register keeps taking ticks while a finished result waits, so
// throughput is one tick per cycle until both registers are full. The dwell,
// precharge and settle times are set through the configuration port
// (indexes 0, 1 and 2, reset values 200, 5570 and 1000 ticks); write them
// only while no tick is in flight. The phase timer is TICK_BITS wide and
// saturates; a configured time the timer cannot reach holds the phase. A
// trip forces shutdown from any phase, and shutdown is left only by reset.
module contactor_precharge_sequencer_core #(
	parameter int unsigned TICK_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Tick input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           loop_tripped,
	input  logic                           start_request,
	input  logic                           stop_request,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           main_closed,
	output logic                           precharge_closed,
	output logic                           discharge_closed,
	output logic                           levitation_power,
	output logic [2:0]                     phase_code,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cps_pkg::CFG_W-1:0]      cfg_data
);
	import cps_pkg::*;

	cps_cfg_t             cfg;

	// Input register stage.
	logic                 valid_s1;
	cps_cmd_t             cmd_s1;

	// Result register stage.
	logic                 valid_s2;
	cps_drive_t           drive_s2;

	// Sequencer state.
	cps_phase_t           phase_q;
	logic [TICK_BITS-1:0] ticks_q;

	cps_phase_t           phase_nxt;
	logic [TICK_BITS-1:0] ticks_nxt;
	cps_drive_t           drive_nxt;

	logic                 s2_open;
	logic                 advance;
	logic                 in_xfer;

	cps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cps_step #(
		.TICK_BITS (TICK_BITS)
	) u_step (
		.phase     (phase_q),
		.ticks     (ticks_q),
		.cmd       (cmd_s1),
		.cfg       (cfg),
		.phase_nxt (phase_nxt),
		.ticks_nxt (ticks_nxt),
		.drive     (drive_nxt)
	);

	// The result register can load when it is empty or its transfer happens now.
	// The held tick moves on, and the state is updated, only when it can.
	assign s2_open  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_open;
	assign in_stall = valid_s1 && !s2_open;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= '{loop_tripped, start_request, stop_request};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			ticks_q <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			ticks_q <= ticks_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_open) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2 <= drive_nxt;
		end
	end

	assign out_valid        = valid_s2;
	assign main_closed      = drive_s2.main_closed;
	assign precharge_closed = drive_s2.precharge_closed;
	assign discharge_closed = drive_s2.discharge_closed;
	assign levitation_power = drive_s2.levitation_power;
	assign phase_code       = drive_s2.phase_code;

`ifndef SYNTHESIS
	// Shutdown is latched until reset.
	a_shutdown_latched: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SHUTDOWN |=> phase_q == PH_SHUTDOWN)
		else $error("sequencer left the shutdown phase");

	// The discharge contactor is never closed together with main or precharge.
	a_no_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(discharge_closed && (main_closed || precharge_closed)))
		else $error("discharge closed together with a bus contactor");

	// Levitation power is on exactly in the run phase.
	a_lev_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (levitation_power == (phase_code == PC_RUN)))
		else $error("levitation power does not match run phase");

	// The input side stalls only while a tick is held that cannot move on.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked tick");
`endif

endmodule

@@ sim/contactor_precharge_sequencer_core_test.sv @@
// Self-checking testbench for the contactor precharge sequencer core.
`timescale 1ns / 1ps

// The sequencer latches its shutdown phase until reset, and reset is applied
// only once. So the run is a single walk through the whole sequence. It
// starts in start and moves through wait, precharge and main on to run. It
// ends in shutdown, where the block stays for the rest of the run.
// Each test task drives one stretch of that walk. A task that sends one
// tick keeps a software copy of the sequencer up to date on every input
// transfer and queues the drive pattern it predicts. A separate process
// takes every result transfer and compares it field by field with the
// oldest queued prediction.
module contactor_precharge_sequencer_core_test;

	import cps_pkg::*;

	localparam int unsigned TICK_BITS = 16;
	localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

	// Index past the end of the register map; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Ways in which the final shutdown is brought about.
	typedef enum int {
		SHUT_BY_STOP,
		SHUT_BY_TRIP,
		SHUT_BY_BOTH
	} shutdown_cause_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 loop_tripped;
	logic                 start_request;
	logic                 stop_request;
	logic                 out_valid;
	logic                 out_stall;
	logic                 main_closed;
	logic                 precharge_closed;
	logic                 discharge_closed;
	logic                 levitation_power;
	logic [2:0]           phase_code;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Software copy of the sequencer: phase, phase timer and registers.
	logic [2:0]           seq_phase;
	logic [TICK_BITS-1:0] seq_ticks;
	cps_cfg_t             seq_cfg;

	// Drive patterns predicted for ticks whose results have not come back yet.
	cps_drive_t drive_q[$];

	// When clear, neither side inserts gaps or stalls.
	bit idling_on;
	int error_count;

	contactor_precharge_sequencer_core #(
		.TICK_BITS(TICK_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.loop_tripped(loop_tripped),
		.start_request(start_request),
		.stop_request(stop_request),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.main_closed(main_closed),
		.precharge_closed(precharge_closed),
		.discharge_closed(discharge_closed),
		.levitation_power(levitation_power),
		.phase_code(phase_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [2:0] got,
			input logic [2:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	function automatic void enter_phase(input logic [2:0] next_phase);
		seq_phase = next_phase;
		seq_ticks = '0;
	endfunction

	// Applies one tick to the software copy and returns the drive pattern
	// that the block must show after that tick.
	function automatic cps_drive_t advance_sequencer(input logic trip,
			input logic start, input logic stop);
		cps_drive_t d;
		// The timer counts first, so a phase entered on this tick shows zero.
		if (seq_ticks != TICK_MAX) begin
			seq_ticks++;
		end
		if (trip) begin
			// A trip in shutdown does not re-enter it; the timer keeps running.
			if (seq_phase != PC_SHUTDOWN) begin
				enter_phase(PC_SHUTDOWN);
			end
		end else begin
			case (seq_phase)
				PC_START: begin
					if (start) enter_phase(PC_WAIT);
				end
				PC_WAIT: begin
					if (seq_ticks >= seq_cfg.wait_start) enter_phase(PC_PRECHARGE);
				end
				PC_PRECHARGE: begin
					if (seq_ticks >= seq_cfg.precharge) enter_phase(PC_MAIN_ON);
				end
				PC_MAIN_ON: begin
					if (seq_ticks >= seq_cfg.settle) enter_phase(PC_RUN);
				end
				PC_RUN: begin
					if (stop) enter_phase(PC_SHUTDOWN);
				end
				PC_SHUTDOWN: begin
				end
				default: begin
					enter_phase(PC_SHUTDOWN);
				end
			endcase
		end
		d.main_closed      = (seq_phase == PC_MAIN_ON) || (seq_phase == PC_RUN);
		d.precharge_closed = (seq_phase == PC_PRECHARGE) || (seq_phase == PC_MAIN_ON);
		d.discharge_closed = !((seq_phase == PC_PRECHARGE) || (seq_phase == PC_MAIN_ON)
				|| (seq_phase == PC_RUN));
		d.levitation_power = (seq_phase == PC_RUN);
		d.phase_code       = seq_phase;
		return d;
	endfunction

	// Sends one tick and returns at the edge where it is transferred. Valid
	// stays high afterwards, so back-to-back ticks need no dead cycle; the
	// next call or a drain lowers it.
	task automatic send_tick(input logic trip, input logic start, input logic stop);
		int gap;
		gap = idling_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		loop_tripped  <= trip;
		start_request <= start;
		stop_request  <= stop;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		drive_q.push_back(advance_sequencer(trip, start, stop));
	endtask

	// Sends ticks with the loop closed and random request bits, except that
	// a start request is never sent in start and a stop request never in run.
	// This keeps the walk in the current phase until its timer runs out.
	task automatic dwell(input int count);
		for (int i = 0; i < count; i++) begin
			send_tick(1'b0, (seq_phase != PC_START) && $urandom_range(0, 1),
					(seq_phase != PC_RUN) && $urandom_range(0, 1));
		end
	endtask

	// Dwells in a timed phase until the software copy says it has moved on.
	task automatic dwell_through_phase();
		logic [2:0] entry_phase;
		entry_phase = seq_phase;
		while (seq_phase == entry_phase) dwell(1);
	endtask

	// Holds off new ticks until every result has come back, so that the
	// block is idle before its registers are touched.
	task automatic drain();
		in_valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
	endtask

	// Writes one register. Valid is left high so that writes can follow one
	// another; close_cfg lowers it after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		case (idx)
			REG_WAIT_START: seq_cfg.wait_start = value;
			REG_PRECHARGE:  seq_cfg.precharge  = value;
			REG_SETTLE:     seq_cfg.settle     = value;
			default: begin
			end
		endcase
	endtask

	task automatic close_cfg();
		cfg_valid <= 1'b0;
	endtask

	// Start phase: a write to the spare index, stop requests that must be
	// ignored, then a start request sent together with a stop request.
	task automatic test_start_phase();
		write_reg(REG_SPARE, 16'hFFFF);
		close_cfg();
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1);
		dwell(40);
		send_tick(1'b0, 1'b1, 1'b1);
	endtask

	// Wait phase on the reset dwell time. The exit must land exactly on the
	// reset value, which also shows the spare write changed nothing.
	task automatic test_wait_default();
		dwell_through_phase();
	endtask

	// Precharge: a stretch on the reset time, then the largest time, which
	// holds the phase, then a time a little above the count, run out with
	// no gaps or stalls.
	task automatic test_precharge_longest();
		dwell(50);
		drain();
		write_reg(REG_PRECHARGE, 16'hFFFF);
		close_cfg();
		dwell(50);
		drain();
		write_reg(REG_PRECHARGE, 16'd120);
		close_cfg();
		idling_on = 1'b0;
		dwell_through_phase();
		idling_on = 1'b1;
	endtask

	// Main on: part of the reset settle time, then the largest settle time,
	// then zero, which is already below the count and ends the phase on the
	// next tick. The wait register is taken to its low end on the way.
	task automatic test_settle_rewrite();
		dwell(100);
		drain();
		write_reg(REG_SETTLE, 16'hFFFF);
		write_reg(REG_WAIT_START, 16'h0000);
		close_cfg();
		dwell(50);
		drain();
		write_reg(REG_SETTLE, 16'h0000);
		close_cfg();
		dwell_through_phase();
	endtask

	// Run: the bulk of the random traffic, with start requests that must be
	// ignored, a stretch with no gaps or stalls, and register writes that
	// must not disturb the run phase.
	task automatic test_run_phase();
		dwell(100);
		idling_on = 1'b0;
		dwell(50);
		idling_on = 1'b1;
		drain();
		write_reg(REG_WAIT_START, 16'($urandom_range(0, 65535)));
		write_reg(REG_PRECHARGE, 16'($urandom_range(0, 65535)));
		write_reg(REG_SETTLE, 16'($urandom_range(0, 65535)));
		write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
		close_cfg();
		dwell(100);
	endtask

	// Shutdown: entered by a stop request, a trip, or both at once, chosen at
	// random. After that the phase must hold whatever arrives.
	task automatic test_shutdown_latch();
		shutdown_cause_t cause;
		cause = shutdown_cause_t'($urandom_range(0, 2));
		case (cause)
			SHUT_BY_STOP: send_tick(1'b0, 1'b0, 1'b1);
			SHUT_BY_TRIP: send_tick(1'b1, 1'b0, 1'b0);
			default:      send_tick(1'b1, 1'b1, 1'b1);
		endcase
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1);
		for (int i = 0; i < 80; i++) begin
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
		end
	endtask

	// Takes result transfers and checks them. After each transfer the result
	// side draws how many cycles it stalls before taking the next one.
	initial begin : result_checker
		int stall_left;
		cps_drive_t want;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && !out_stall) begin
				if (drive_q.size() == 0) begin
					report_mismatch("result transfer with no tick outstanding");
				end else begin
					want = drive_q.pop_front();
					check_field("main_closed", {2'b00, main_closed},
							{2'b00, want.main_closed});
					check_field("precharge_closed", {2'b00, precharge_closed},
							{2'b00, want.precharge_closed});
					check_field("discharge_closed", {2'b00, discharge_closed},
							{2'b00, want.discharge_closed});
					check_field("levitation_power", {2'b00, levitation_power},
							{2'b00, want.levitation_power});
					check_field("phase_code", phase_code, want.phase_code);
				end
				stall_left = idling_on ? $urandom_range(0, 9) : 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		loop_tripped  <= 1'b0;
		start_request <= 1'b0;
		stop_request  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_WAIT_START;
		cfg_data      <= '0;
		error_count   = 0;
		idling_on     = 1'b1;
		seq_phase     = PC_START;
		seq_ticks     = '0;
		seq_cfg.wait_start = WAIT_START_RST;
		seq_cfg.precharge  = PRECHARGE_RST;
		seq_cfg.settle     = SETTLE_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_start_phase();
		test_wait_default();
		test_precharge_longest();
		test_settle_rewrite();
		test_run_phase();
		test_shutdown_latch();

		// Let the last results come back, then keep clocking so that a stray
		// extra result would show up.
		drain();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
